FILE: rtl/core/pzt_pkg.sv
// Shared types and constants of the pinch zoom gesture tracker.
// Used by every module of the block; depends on nothing else.
package pzt_pkg;

  // Coordinate width range and default.
  localparam int COORD_BITS_DEF = 12;
  localparam int COORD_MAX_BITS = 16;
  // Widest squared distance any legal coordinate width produces.
  localparam int D2_W = 2 * COORD_MAX_BITS + 1;

  localparam int LIMIT_W = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);
  localparam int POS_W = 12;
  localparam int ID_W = 8;
  localparam int ZOOM_W = 16;
  localparam int SHIFT_W = 14;
  localparam int SHIFT_MAX = 8190;
  localparam logic [ZOOM_W-1:0] ZOOM_SAT = '1;

  // Division yields a 32-bit quotient, square root a 16-bit root.
  localparam int QUO_W = 32;
  localparam int FRAC_SHIFT = 24;

  typedef enum logic [1:0] {
    CMD_DOWN   = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_UP     = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQ0,
    F_SQ1,
    F_DEC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SQRT
  } back_state_t;

  // One classified event handed from the front to the back.
  typedef struct packed {
    logic                      is_pinch;
    logic                      calc;
    logic [D2_W-1:0]           new2;
    logic [D2_W-1:0]           old2;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
  } job_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

FILE: rtl/core/pzt_front.sv
// Front end: accepts touch events, keeps the finger slots and classifies events.
// Depends on pzt_pkg; pushes one job per event into the queue.
module pzt_front import pzt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  input  logic [ID_W-1:0]    in_finger_id,
  input  logic [LIMIT_W-1:0] move_limit,
  output logic               push,
  output job_t               push_job,
  input  logic               q_full
);

  localparam int CW   = COORD_BITS;
  localparam int MW   = (CW < POS_W) ? CW : POS_W;
  localparam int MULW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int SUMW = 2 * MULW + 1;
  localparam int SW   = CW + 3;

  front_state_t state_r, state_nxt;

  logic [1:0]      cmd_r;
  logic [CW-1:0]   px_r, py_r;
  logic [ID_W-1:0] fid_r;

  logic            a_used_r, b_used_r, a_first_r, cancel_r;
  logic [ID_W-1:0] a_id_r, b_id_r;
  logic [CW-1:0]   ax_r, ay_r, bx_r, by_r, stx_r, sty_r;
  logic [SUMW-1:0] sum_a_r, sum_b_r;

  logic on_a, on_b, both;
  logic [CW-1:0] ox, oy;
  logic [MULW-1:0] op_x, op_y;
  logic [2*MULW-1:0] prod_x, prod_y;
  logic [SUMW-1:0] prod_sum;

  // Slot match against the latched event.
  assign on_a = a_used_r && (a_id_r == fid_r);
  assign on_b = b_used_r && (b_id_r == fid_r);
  assign both = a_used_r && b_used_r;
  assign ox   = on_a ? bx_r : ax_r;
  assign oy   = on_a ? by_r : ay_r;

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] p, input logic [CW-1:0] q);
    return (p > q) ? (p - q) : (q - p);
  endfunction

  // Shared squaring pair: old distance or start distance, then new distance or limit.
  always_comb begin
    op_x = '0;
    op_y = '0;
    if (state_r == F_SQ0) begin
      if (both) begin
        op_x = MULW'(absdiff(ax_r, bx_r));
        op_y = MULW'(absdiff(ay_r, by_r));
      end else begin
        op_x = MULW'(absdiff(stx_r, px_r));
        op_y = MULW'(absdiff(sty_r, py_r));
      end
    end else begin
      if (both) begin
        op_x = MULW'(absdiff(px_r, ox));
        op_y = MULW'(absdiff(py_r, oy));
      end else begin
        op_x = MULW'(move_limit);
        op_y = '0;
      end
    end
    prod_x   = op_x * op_x;
    prod_y   = op_y * op_y;
    prod_sum = SUMW'(prod_x) + SUMW'(prod_y);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_SQ0;
      F_SQ0:   state_nxt = F_SQ1;
      F_SQ1:   state_nxt = F_DEC;
      F_DEC:   if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready = (state_r == F_IDLE);
    push     = (state_r == F_DEC) && !q_full;
  end

  // Center shift, clamped to the output range.
  logic signed [SW-1:0] sx_raw, sy_raw;
  logic signed [SHIFT_W-1:0] sx_cl, sy_cl;

  always_comb begin
    sx_raw = (SW'(px_r) + SW'(ox)) - (SW'(ax_r) + SW'(bx_r));
    sy_raw = (SW'(py_r) + SW'(oy)) - (SW'(ay_r) + SW'(by_r));
    if (sx_raw > SW'(SHIFT_MAX))       sx_cl = SHIFT_W'(SHIFT_MAX);
    else if (sx_raw < -SW'(SHIFT_MAX)) sx_cl = -SHIFT_W'(SHIFT_MAX);
    else                               sx_cl = SHIFT_W'(sx_raw);
    if (sy_raw > SW'(SHIFT_MAX))       sy_cl = SHIFT_W'(SHIFT_MAX);
    else if (sy_raw < -SW'(SHIFT_MAX)) sy_cl = -SHIFT_W'(SHIFT_MAX);
    else                               sy_cl = SHIFT_W'(sy_raw);
  end

  // Event classification and the job it produces.
  logic pinch_mv;
  assign pinch_mv = (cmd_r == CMD_MOVE) && (on_a || on_b) && both;

  always_comb begin
    push_job          = '0;
    push_job.calc     = pinch_mv;
    push_job.old2     = D2_W'(sum_a_r);
    push_job.new2     = D2_W'(sum_b_r);
    if (pinch_mv) begin
      push_job.shift_x = sx_cl;
      push_job.shift_y = sy_cl;
    end
    unique case (cmd_r)
      CMD_DOWN: begin
        if (on_a || (!on_b && !a_used_r)) push_job.is_pinch = b_used_r;
        else if (on_b || !b_used_r)       push_job.is_pinch = a_used_r;
      end
      CMD_MOVE: push_job.is_pinch = pinch_mv;
      CMD_UP: begin
        if (on_b)      push_job.is_pinch = cancel_r || a_first_r;
        else if (on_a) push_job.is_pinch = cancel_r || !a_first_r;
      end
      default: push_job.is_pinch = 1'b0;
    endcase
  end

  // Control registers and slot state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      a_used_r  <= 1'b0;
      b_used_r  <= 1'b0;
      a_first_r <= 1'b0;
      cancel_r  <= 1'b0;
      a_id_r    <= '0;
      b_id_r    <= '0;
      ax_r      <= '0;
      ay_r      <= '0;
      bx_r      <= '0;
      by_r      <= '0;
      stx_r     <= '0;
      sty_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        unique case (cmd_r)
          CMD_DOWN: begin
            if (on_a || (!on_b && !a_used_r)) begin
              a_used_r  <= 1'b1;
              a_id_r    <= fid_r;
              ax_r      <= px_r;
              ay_r      <= py_r;
              stx_r     <= px_r;
              sty_r     <= py_r;
              cancel_r  <= 1'b0;
              a_first_r <= !b_used_r;
            end else if (on_b) begin
              bx_r     <= px_r;
              by_r     <= py_r;
              stx_r    <= px_r;
              sty_r    <= py_r;
              cancel_r <= 1'b0;
            end else if (!b_used_r) begin
              b_used_r  <= 1'b1;
              b_id_r    <= fid_r;
              bx_r      <= px_r;
              by_r      <= py_r;
              stx_r     <= px_r;
              sty_r     <= py_r;
              cancel_r  <= 1'b0;
              a_first_r <= a_used_r;
            end
          end
          CMD_MOVE: begin
            if (on_a || on_b) begin
              if (!both && (SUMW'(sum_a_r) > sum_b_r)) begin
                if (a_used_r) a_used_r <= 1'b0;
                else          b_used_r <= 1'b0;
              end else if (on_a) begin
                ax_r <= px_r;
                ay_r <= py_r;
              end else begin
                bx_r <= px_r;
                by_r <= py_r;
              end
            end
          end
          CMD_UP: begin
            if (on_b)      b_used_r <= 1'b0;
            else if (on_a) a_used_r <= 1'b0;
          end
          default: cancel_r <= 1'b1;
        endcase
      end
    end
  end

  // Event latch and squared distances.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      px_r  <= CW'(in_pos_x[MW-1:0]);
      py_r  <= CW'(in_pos_y[MW-1:0]);
      fid_r <= in_finger_id;
    end
    if (state_r == F_SQ0) sum_a_r <= prod_sum;
    if (state_r == F_SQ1) sum_b_r <= prod_sum;
  end

endmodule

FILE: rtl/core/pzt_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on pzt_pkg for the job type.
module pzt_queue import pzt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full    = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on a transfer in");

endmodule

FILE: rtl/core/pzt_back.sv
// Back end: zoom ratio by iterative division and square root, result register.
// Depends on pzt_pkg; pops jobs from the queue.
module pzt_back import pzt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  job_t q_job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic out_is_pinch,
  output logic [ZOOM_W-1:0] out_zoom_ratio,
  output logic signed [SHIFT_W-1:0] out_shift_x,
  output logic signed [SHIFT_W-1:0] out_shift_y
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  back_state_t state_r, state_nxt;

  logic [D2_W-1:0]  div_r;
  logic [D2_W:0]    rem_r;
  logic [QUO_W-1:0] nlo_r, quo_r;
  logic [QUO_W-1:0] v_r, res_r, bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r, is_pinch_r;
  logic [ZOOM_W-1:0] zoom_r;
  logic signed [SHIFT_W-1:0] sx_r, sy_r;

  logic slot_free, start, sat, last;
  logic [D2_W:0] rem_sh;
  logic [QUO_W-1:0] trial;

  assign slot_free = !out_valid_r || out_ready;
  assign start     = (state_r == B_IDLE) && !q_empty && slot_free;
  assign sat       = (q_job.old2 == '0) ||
                     ({8'd0, q_job.new2} >= {q_job.old2, 8'd0});
  assign last      = (cnt_r == '0);
  assign rem_sh    = {rem_r[D2_W-1:0], nlo_r[QUO_W-1]};
  assign trial     = res_r + bit_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (start && q_job.calc && !sat) state_nxt = B_DIV;
      B_DIV:   if (last) state_nxt = B_SQRT;
      B_SQRT:  if (bit_r == '0 && slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs toward the queue and the result channel.
  always_comb begin
    pop            = start;
    out_valid      = out_valid_r;
    out_is_pinch   = is_pinch_r;
    out_zoom_ratio = zoom_r;
    out_shift_x    = sx_r;
    out_shift_y    = sy_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start && !(q_job.calc && !sat)) out_valid_r <= 1'b1;
      else if (state_r == B_SQRT && bit_r == '0 && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath: restoring division, then bitwise square root.
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          is_pinch_r <= q_job.is_pinch;
          sx_r       <= q_job.shift_x;
          sy_r       <= q_job.shift_y;
          zoom_r     <= q_job.calc ? ZOOM_SAT : '0;
          div_r      <= q_job.old2;
          rem_r      <= (D2_W+1)'(q_job.new2 >> (QUO_W - FRAC_SHIFT));
          nlo_r      <= {q_job.new2[QUO_W-FRAC_SHIFT-1:0], FRAC_SHIFT'(0)};
          cnt_r      <= CNT_W'(QUO_W - 1);
        end
      end
      B_DIV: begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_r <= rem_sh - {1'b0, div_r};
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        nlo_r <= {nlo_r[QUO_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (last) begin
          v_r   <= (rem_sh >= {1'b0, div_r}) ? {quo_r[QUO_W-2:0], 1'b1}
                                             : {quo_r[QUO_W-2:0], 1'b0};
          res_r <= '0;
          bit_r <= QUO_W'(1) << (QUO_W - 2);
        end
      end
      B_SQRT: begin
        if (bit_r != '0) begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else if (slot_free) begin
          zoom_r <= ZOOM_W'(res_r);
        end
      end
      default: ;
    endcase
  end

  a_sqrt_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQRT && bit_r == '0) |-> (res_r[QUO_W-1:ZOOM_W] == '0))
    else $error("square root exceeds the zoom range");
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> !pop)
    else $error("job taken while the ratio unit is busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(zoom_r) && $stable(is_pinch_r)))
    else $error("pending result changed before its transfer");

endmodule

FILE: rtl/core/pinch_zoom_gesture_tracker_unit.sv
// Pinch zoom gesture tracker: tracks two fingers and reports pinch zoom and pan.
// Top level; instantiates pzt_front, pzt_queue and pzt_back from pzt_pkg.
// Each touch event yields exactly one result. Down, up, cancel and single-finger
// moves pass through the front end's latch, squaring and decision states and then
// the back end's result register; a move while two fingers are down also runs the
// zoom unit, unless the ratio saturates: restoring division, then square root,
// with a one-bit-per-cycle divider. A two-entry queue lets the front end take the
// next event while a ratio is still being computed.
module pinch_zoom_gesture_tracker_unit import pzt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [LIMIT_W-1:0]        cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic [POS_W-1:0]          in_pos_x,
  input  logic [POS_W-1:0]          in_pos_y,
  input  logic [ID_W-1:0]           in_finger_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_is_pinch,
  output logic [ZOOM_W-1:0]         out_zoom_ratio,
  output logic signed [SHIFT_W-1:0] out_shift_x,
  output logic signed [SHIFT_W-1:0] out_shift_y
);

  logic [LIMIT_W-1:0] move_limit_r;
  logic push, q_full, q_empty, pop;
  job_t push_job, pop_job;

  // Move limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) move_limit_r <= LIMIT_RESET;
    else if (cfg_wr_en) move_limit_r <= cfg_wr_data;
  end

  pzt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_pos_x, .in_pos_y,
    .in_finger_id, .move_limit(move_limit_r), .push, .push_job, .q_full
  );

  pzt_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full), .pop, .empty(q_empty),
    .pop_job
  );

  pzt_back u_back (
    .clk, .rst_n, .q_empty, .q_job(pop_job), .pop, .out_valid, .out_ready,
    .out_is_pinch, .out_zoom_ratio, .out_shift_x, .out_shift_y
  );

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for pinch_zoom_gesture_tracker_unit: random and directed touch events
// checked against a behavioral tracker model. Depends on pzt_pkg and the RTL.
`timescale 1ns / 100ps

// Tracker model plus a queue of expected gesture results.
class gesture_scoreboard;
  typedef struct packed {
    logic                       pinch;
    logic [15:0]                zoom;
    logic signed [13:0]         sx;
    logic signed [13:0]         sy;
  } gesture_t;

  gesture_t pending_q[$];
  logic [11:0] drift_limit;
  bit a_used, b_used, a_first, cancelled;
  logic [7:0] a_id, b_id;
  logic [11:0] ax, ay, bx, by, sx0, sy0;
  int errors;
  int pinch_moves;

  function new();
    errors = 0;
    pinch_moves = 0;
    clear();
  endfunction

  function void clear();
    drift_limit = 12'd20;
    a_used = 0; b_used = 0; a_first = 0; cancelled = 0;
    a_id = 0; b_id = 0;
    ax = 0; ay = 0; bx = 0; by = 0; sx0 = 0; sy0 = 0;
  endfunction

  function longint dist2(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy;
    dx = x1 - x2;
    dy = y1 - y2;
    return dx * dx + dy * dy;
  endfunction

  function longint root(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v)
        r = r | (longint'(1) << b);
    end
    return r;
  endfunction

  function logic [13:0] clamp_shift(longint s);
    if (s > 8190) s = 8190;
    if (s < -8190) s = -8190;
    return s[13:0];
  endfunction

  // Apply one accepted event to the model and queue its result.
  function void note_event(logic [1:0] cmd, logic [11:0] px, logic [11:0] py,
                           logic [7:0] fid);
    gesture_t g;
    bit on_a, on_b;
    longint old2, new2, q, r, ox, oy;
    on_a = a_used && a_id == fid;
    on_b = b_used && b_id == fid;
    g = '0;
    case (cmd)
      pzt_pkg::CMD_DOWN: begin
        if (on_a || (!on_b && !a_used)) begin
          a_used = 1; a_id = fid; ax = px; ay = py; sx0 = px; sy0 = py;
          cancelled = 0; a_first = !b_used; g.pinch = b_used;
        end else if (on_b) begin
          bx = px; by = py; sx0 = px; sy0 = py; cancelled = 0; g.pinch = a_used;
        end else if (!b_used) begin
          b_used = 1; b_id = fid; bx = px; by = py; sx0 = px; sy0 = py;
          cancelled = 0; a_first = a_used; g.pinch = a_used;
        end
      end
      pzt_pkg::CMD_MOVE: begin
        if (on_a || on_b) begin
          if (!(a_used && b_used)) begin
            if (dist2(sx0, sy0, px, py) > longint'(drift_limit) * drift_limit) begin
              if (a_used) a_used = 0;
              else b_used = 0;
            end else if (on_a) begin
              ax = px; ay = py;
            end else begin
              bx = px; by = py;
            end
          end else begin
            ox = on_a ? bx : ax;
            oy = on_a ? by : ay;
            old2 = dist2(ax, ay, bx, by);
            new2 = dist2(px, py, ox, oy);
            g.zoom = 16'hFFFF;
            if (old2 != 0) begin
              q = (new2 << 24) / old2;
              r = root(q);
              g.zoom = r > 65535 ? 16'hFFFF : r[15:0];
            end
            g.sx = clamp_shift((longint'(px) + ox) - (longint'(ax) + bx));
            g.sy = clamp_shift((longint'(py) + oy) - (longint'(ay) + by));
            if (on_a) begin
              ax = px; ay = py;
            end else begin
              bx = px; by = py;
            end
            g.pinch = 1;
            pinch_moves++;
          end
        end
      end
      pzt_pkg::CMD_UP: begin
        if (on_b) begin
          b_used = 0; g.pinch = cancelled || a_first;
        end else if (on_a) begin
          a_used = 0; g.pinch = cancelled || !a_first;
        end
      end
      default: cancelled = 1;
    endcase
    pending_q.push_back(g);
  endfunction

  task report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Compare one transfer from the result channel with the oldest expectation.
  task check_result(logic pinch, logic [15:0] zoom, logic signed [13:0] sx,
                    logic signed [13:0] sy);
    gesture_t g;
    if (pending_q.size() == 0) begin
      report("unexpected result", 1, 0);
      return;
    end
    g = pending_q.pop_front();
    if (pinch !== g.pinch) report("is_pinch", pinch, g.pinch);
    if (zoom !== g.zoom) report("zoom_ratio", zoom, g.zoom);
    if (sx !== g.sx) report("shift_x", sx, g.sx);
    if (sy !== g.sy) report("shift_y", sy, g.sy);
  endtask
endclass

module tb_top;
  import pzt_pkg::*;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  logic in_valid, in_ready;
  logic [1:0] in_cmd;
  logic [POS_W-1:0] in_pos_x, in_pos_y;
  logic [ID_W-1:0] in_finger_id;
  logic out_valid, out_ready;
  logic out_is_pinch;
  logic [ZOOM_W-1:0] out_zoom_ratio;
  logic signed [SHIFT_W-1:0] out_shift_x, out_shift_y;

  gesture_scoreboard sb;
  int events_sent;
  int stall_count;
  int ready_gap;
  int watchdog;
  bit stim_done;

  localparam int WATCHDOG_LIMIT = 5000;

  pinch_zoom_gesture_tracker_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_finger_id(in_finger_id),
    .out_valid(out_valid), .out_ready(out_ready), .out_is_pinch(out_is_pinch),
    .out_zoom_ratio(out_zoom_ratio), .out_shift_x(out_shift_x),
    .out_shift_y(out_shift_y)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Send one touch event after a random gap and wait for its transfer.
  // Valid stays high across back-to-back events; callers that pause drop it.
  task send_event(logic [1:0] cmd, logic [11:0] px, logic [11:0] py, logic [7:0] fid);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_cmd <= cmd; in_pos_x <= px; in_pos_y <= py; in_finger_id <= fid;
    do @(posedge clk); while (!in_ready);
    sb.note_event(cmd, px, py, fid);
    events_sent++;
  endtask

  // Write the drift limit once every expected result is back and the block is idle.
  task write_limit(logic [11:0] value);
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_wr_en <= 1; cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.drift_limit = value;
  endtask

  // Result side: random stalls with stretches of always ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_is_pinch, out_zoom_ratio, out_shift_x, out_shift_y);
      ready_gap = (events_sent / 100) % 3 == 0 ? 0 : $urandom_range(0, 6);
      if (ready_gap == 0) begin
        out_ready <= 1;
      end else begin
        out_ready <= 0;
        stall_count <= ready_gap - 1;
      end
    end else if (stall_count > 0) begin
      stall_count <= stall_count - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results pending", sb.pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Random gesture sequence: mostly well-formed two-finger pinches.
  task random_gesture();
    logic [7:0] f1, f2;
    logic [11:0] x1, y1, x2, y2;
    int n;
    f1 = 8'($urandom);
    f2 = 8'($urandom);
    x1 = 12'($urandom); y1 = 12'($urandom); x2 = 12'($urandom); y2 = 12'($urandom);
    case ($urandom_range(0, 9))
      0, 1: send_event(2'($urandom), 12'($urandom), 12'($urandom),
                       8'($urandom_range(0, 3)));
      2: begin
        // Lone finger drifting around its start point.
        send_event(CMD_DOWN, x1, y1, f1);
        n = $urandom_range(1, 4);
        repeat (n) send_event(CMD_MOVE, 12'(x1 + $urandom_range(0, 60) - 30),
                              12'(y1 + $urandom_range(0, 60) - 30), f1);
        send_event(CMD_UP, x1, y1, f1);
      end
      default: begin
        send_event(CMD_DOWN, x1, y1, f1);
        if ($urandom_range(0, 3) == 0) send_event(CMD_CANCEL, 12'd0, 12'd0, f1);
        send_event(CMD_DOWN, x2, y2, f2);
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 1))
            send_event(CMD_MOVE, $urandom_range(0, 1) ? 12'(x1 + $urandom_range(0, 200) - 100)
                       : 12'($urandom), 12'($urandom), f1);
          else
            send_event(CMD_MOVE, 12'($urandom), 12'($urandom), f2);
        end
        send_event(CMD_UP, 12'd0, 12'd0, $urandom_range(0, 1) ? f1 : f2);
        send_event(CMD_UP, 12'd0, 12'd0, $urandom_range(0, 1) ? f1 : f2);
      end
    endcase
  endtask

  initial begin
    sb = new();
    rst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0;
    in_valid = 0; in_cmd = CMD_DOWN; in_pos_x = 0; in_pos_y = 0; in_finger_id = 0;
    out_ready = 0; stall_count = 0; ready_gap = 0; events_sent = 0; watchdog = 0;
    stim_done = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, zero old distance, drop, re-down, ignored cases.
    send_event(CMD_MOVE, 12'd5, 12'd5, 8'd9);
    send_event(CMD_UP, 12'd0, 12'd0, 8'd9);
    send_event(CMD_DOWN, 12'd0, 12'd0, 8'd0);
    send_event(CMD_MOVE, 12'd12, 12'd16, 8'd0);
    send_event(CMD_MOVE, 12'd13, 12'd16, 8'd0);
    send_event(CMD_DOWN, 12'd100, 12'd100, 8'd255);
    send_event(CMD_DOWN, 12'd4095, 12'd4095, 8'd255);
    send_event(CMD_DOWN, 12'd0, 12'd0, 8'd0);
    send_event(CMD_DOWN, 12'd0, 12'd0, 8'd0);
    send_event(CMD_DOWN, 12'd7, 12'd7, 8'd0);
    send_event(CMD_MOVE, 12'd4095, 12'd4095, 8'd255);
    send_event(CMD_MOVE, 12'd4095, 12'd4095, 8'd0);
    send_event(CMD_MOVE, 12'd0, 12'd0, 8'd0);
    send_event(CMD_MOVE, 12'd1, 12'd0, 8'd255);
    send_event(CMD_DOWN, 12'd5, 12'd5, 8'd77);
    send_event(CMD_CANCEL, 12'd4095, 12'd4095, 8'd255);
    send_event(CMD_UP, 12'd0, 12'd0, 8'd0);
    send_event(CMD_UP, 12'd0, 12'd0, 8'd255);
    send_event(CMD_UP, 12'd0, 12'd0, 8'd255);

    write_limit(12'd0);
    send_event(CMD_DOWN, 12'd50, 12'd50, 8'd3);
    send_event(CMD_MOVE, 12'd50, 12'd50, 8'd3);
    send_event(CMD_MOVE, 12'd51, 12'd50, 8'd3);

    // Random phases over several drift limits, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_limit(12'd4095);
        1: write_limit(12'd20);
        2: write_limit(12'd0);
        default: write_limit(12'($urandom_range(1, 200)));
      endcase
      while (events_sent < 150 * (phase + 1) + 25) random_gesture();
    end
    in_valid <= 0;
    stim_done = 1;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d events, %0d of them pinch moves", events_sent, sb.pinch_moves);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
